// ===== rtl/gtl_pkg.sv =====
// Shared widths, codes and types of the IPv4 trie lookup block.
package gtl_pkg;

  // Field widths
  localparam int unsigned RecW      = 24;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned IdxW      = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountryW  = 8;
  localparam int unsigned OffsetW   = 27;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned LevelW    = 5;
  localparam int unsigned NodeW     = 2 * RecW;

  // Parameter defaults
  localparam int unsigned NodeAddrBitsDefault = 16;
  localparam int unsigned LastCountryDefault  = 250;

  // Top address bit, taken first
  localparam logic [LevelW-1:0] TopBit = LevelW'(31);

  // Register reset values
  localparam logic [RecW-1:0]    TerminalReset = RecW'(24'hFFFF00);
  localparam logic [OffsetW-1:0] Term5Reset    = OffsetW'(5 * 24'hFFFF00);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TERMINAL_OFFSET = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_RECORD_MODE     = CfgIdxW'(1);

  // Item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_FOUND  = 2'd0,
    STATUS_NODATA = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_BEYOND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_WALK,
    WS_DECODE
  } walk_state_e;

  typedef enum logic [1:0] {
    END_TERMINAL,
    END_NODATA,
    END_BEYOND
  } walk_end_e;

  // Configuration seen by the walker
  typedef struct packed {
    logic [RecW-1:0]    terminal_offset;
    logic [OffsetW-1:0] term5;
    logic               record_mode;
  } cfg_t;

endpackage

// ===== rtl/gtl_node_mem.sv =====
// Trie node store: one write port, one registered read port.
module gtl_node_mem #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gtl_walker.sv =====
// Trie walker: takes one address bit per cycle, one node read per bit, then decodes.
module gtl_walker #(
  parameter int unsigned NODE_ADDR_BITS = 16,
  parameter int unsigned LAST_COUNTRY   = 250
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  input  logic [gtl_pkg::AddrW-1:0]         address_i,
  input  gtl_pkg::cfg_t                     cfg_i,
  output logic                              rd_en_o,
  output logic [NODE_ADDR_BITS-1:0]         rd_addr_o,
  input  logic [gtl_pkg::NodeW-1:0]         rd_data_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [gtl_pkg::StatusW-1:0]       status_o,
  output logic [gtl_pkg::CountryW-1:0]      country_o,
  output logic [gtl_pkg::OffsetW-1:0]       record_offset_o
);

  import gtl_pkg::*;

  walk_state_e         state_q, state_d;
  logic [AddrW-1:0]    addr_q;
  logic [LevelW-1:0]   level_q;
  logic [RecW-1:0]     rec_q;
  walk_end_e           end_q;
  logic                done_q;
  logic [StatusW-1:0]  status_q;
  logic [CountryW-1:0] country_q;
  logic [OffsetW-1:0]  offset_q;

  logic                bit_now;
  logic [RecW-1:0]     sel_rec;
  logic                is_term;
  logic                is_beyond;
  logic                last_lvl;
  logic                stop;

  status_e             dec_status;
  logic [CountryW-1:0] dec_country;
  logic [OffsetW-1:0]  dec_offset;
  logic [RecW-1:0]     diff;

  // Record picked by the current address bit
  assign bit_now   = addr_q[AddrW-1];
  assign sel_rec   = bit_now ? rd_data_i[NodeW-1:RecW] : rd_data_i[RecW-1:0];
  assign is_term   = sel_rec >= cfg_i.terminal_offset;
  assign is_beyond = (sel_rec >> NODE_ADDR_BITS) != '0;
  assign last_lvl  = level_q == '0;
  assign stop      = is_term || last_lvl || is_beyond;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      WS_IDLE:   if (go_i) state_d = WS_WALK;
      WS_WALK:   if (stop) state_d = WS_DECODE;
      WS_DECODE: state_d = WS_IDLE;
      default:   state_d = WS_IDLE;
    endcase
  end

  // Memory read control
  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    busy_o    = 1'b1;
    case (state_q)
      WS_IDLE: begin
        rd_en_o = go_i;
        busy_o  = 1'b0;
      end
      WS_WALK: begin
        rd_en_o   = !stop;
        rd_addr_o = sel_rec[NODE_ADDR_BITS-1:0];
      end
      WS_DECODE: ;
      default: ;
    endcase
  end

  // Final decode of the walk end
  assign diff = rec_q - cfg_i.terminal_offset;

  always_comb begin
    dec_status  = STATUS_FOUND;
    dec_country = '0;
    dec_offset  = '0;
    case (end_q)
      END_TERMINAL: begin
        if (rec_q == cfg_i.terminal_offset) begin
          dec_status = STATUS_NODATA;
        end else if (!cfg_i.record_mode) begin
          if (diff > RecW'(LAST_COUNTRY)) begin
            dec_status = STATUS_RANGE;
          end else begin
            dec_country = diff[CountryW-1:0];
          end
        end else begin
          dec_offset = OffsetW'(rec_q) + cfg_i.term5;
        end
      end
      END_NODATA: dec_status = STATUS_NODATA;
      END_BEYOND: dec_status = STATUS_BEYOND;
      default:    dec_status = STATUS_NODATA;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == WS_DECODE;
    end
  end

  // Address shift register, level count and walk end
  always_ff @(posedge clk_i) begin
    if (state_q == WS_IDLE && go_i) begin
      addr_q  <= address_i;
      level_q <= TopBit;
    end else if (state_q == WS_WALK) begin
      if (stop) begin
        rec_q <= sel_rec;
        end_q <= is_term ? END_TERMINAL : (last_lvl ? END_NODATA : END_BEYOND);
      end else begin
        addr_q  <= {addr_q[AddrW-2:0], 1'b0};
        level_q <= level_q - LevelW'(1);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (state_q == WS_DECODE) begin
      status_q  <= dec_status;
      country_q <= dec_country;
      offset_q  <= dec_offset;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign country_o       = country_q;
  assign record_offset_o = offset_q;

  // Checks
  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> state_q == WS_IDLE)
    else $error("lookup started while walking");

  a_read_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_WALK && rd_en_o) |-> !is_beyond && !is_term)
    else $error("node read outside store or past terminal");

  a_last_level_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_WALK && last_lvl) |=> state_q == WS_DECODE)
    else $error("walk ran past the last address bit");

  a_done_after_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == WS_DECODE))
    else $error("result without decode");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STATUS_FOUND) |-> (country_q == '0 && offset_q == '0))
    else $error("error result carries data");

endmodule

// ===== rtl/ipv4_geo_trie_lookup.sv =====
// Top level of the IPv4 trie lookup: configuration registers, node store and walker.
//
//   channel  handshake                   payload
//   item in  start, busy                 kind_i, node_index_i, left_record_i,
//                                        right_record_i, address_i
//   result   done_o (one-cycle strobe)   status_o, country_o, record_offset_o
//   config   cfg_valid_i, cfg_ready_o    cfg_index_i, cfg_data_i
//
// A node write leaves busy low; it gives no result.
// A lookup holds busy through its walk, one step per address bit used (1 to 32),
// each bound by one dependent read of the single node memory port, and a decode state.
// done_o pulses in the first cycle with busy low after a lookup; a new item may be
// taken in that cycle.
// Reset clears configuration and control state; node memory and results are not cleared.
// The receiver cannot stall; cfg_ready_o is always high.
module ipv4_geo_trie_lookup #(
  parameter int unsigned NODE_ADDR_BITS = gtl_pkg::NodeAddrBitsDefault,
  parameter int unsigned LAST_COUNTRY   = gtl_pkg::LastCountryDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [gtl_pkg::IdxW-1:0]      node_index_i,
  input  logic [gtl_pkg::RecW-1:0]      left_record_i,
  input  logic [gtl_pkg::RecW-1:0]      right_record_i,
  input  logic [gtl_pkg::AddrW-1:0]     address_i,
  output logic                          done_o,
  output logic [gtl_pkg::StatusW-1:0]   status_o,
  output logic [gtl_pkg::CountryW-1:0]  country_o,
  output logic [gtl_pkg::OffsetW-1:0]   record_offset_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gtl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gtl_pkg::RecW-1:0]      cfg_data_i
);

  import gtl_pkg::*;

  localparam int unsigned IdxExtW = RecW;

  logic [RecW-1:0]           terminal_q;
  logic [OffsetW-1:0]        term5_q;
  logic                      mode_q;
  cfg_t                      cfg;

  logic                      accept;
  logic                      go;
  logic                      wr_en;
  logic [IdxExtW-1:0]        idx_ext;
  logic                      rd_en;
  logic [NODE_ADDR_BITS-1:0] rd_addr;
  logic [NodeW-1:0]          rd_data;
  logic                      walk_busy;

  // Item handshake
  assign busy   = walk_busy;
  assign accept = start && !walk_busy;
  assign go     = accept && kind_i == KIND_LOOKUP;

  // Node writes beyond the store are dropped
  assign idx_ext = IdxExtW'(node_index_i);
  assign wr_en   = accept && kind_i == KIND_WRITE && (idx_ext >> NODE_ADDR_BITS) == '0;

  // Configuration registers; five times the terminal offset is kept ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      terminal_q <= TerminalReset;
      term5_q    <= Term5Reset;
      mode_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TERMINAL_OFFSET: begin
          terminal_q <= cfg_data_i;
          term5_q    <= OffsetW'(cfg_data_i) + {1'b0, cfg_data_i, 2'b00};
        end
        CFG_RECORD_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.terminal_offset = terminal_q;
  assign cfg.term5           = term5_q;
  assign cfg.record_mode     = mode_q;

  // Node store
  gtl_node_mem #(
    .AW(NODE_ADDR_BITS),
    .DW(NodeW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_ext[NODE_ADDR_BITS-1:0]),
    .wdata_i ({right_record_i, left_record_i}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Walker
  gtl_walker #(
    .NODE_ADDR_BITS(NODE_ADDR_BITS),
    .LAST_COUNTRY  (LAST_COUNTRY)
  ) u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .go_i            (go),
    .address_i       (address_i),
    .cfg_i           (cfg),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .busy_o          (walk_busy),
    .done_o          (done_o),
    .status_o        (status_o),
    .country_o       (country_o),
    .record_offset_o (record_offset_o)
  );

endmodule

// ===== tb/tb_ipv4_geo_trie_lookup.sv =====
// Self-checking testbench for the IPv4 trie lookup: node writes, lookups and register settings.
`timescale 1ns / 1ps

module tb_ipv4_geo_trie_lookup;
  import gtl_pkg::*;

  localparam int unsigned STORE_DEPTH  = 1 << NodeAddrBitsDefault;
  localparam int unsigned LAST_CTRY    = LastCountryDefault;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_DEPTH    = 40;

  // One item on the command port
  typedef struct {
    logic              kind;
    logic [IdxW-1:0]   idx;
    logic [RecW-1:0]   left;
    logic [RecW-1:0]   right;
    logic [AddrW-1:0]  addr;
  } trie_item_t;

  // One lookup result
  typedef struct {
    status_e             status;
    logic [CountryW-1:0] country;
    logic [OffsetW-1:0]  offset;
  } lookup_res_t;

  // Clock, reset and block ports
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 kind_i         = KIND_WRITE;
  logic [IdxW-1:0]      node_index_i   = '0;
  logic [RecW-1:0]      left_record_i  = '0;
  logic [RecW-1:0]      right_record_i = '0;
  logic [AddrW-1:0]     address_i      = '0;
  logic                 done_o;
  logic [StatusW-1:0]   status_o;
  logic [CountryW-1:0]  country_o;
  logic [OffsetW-1:0]   record_offset_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i    = '0;
  logic [RecW-1:0]      cfg_data_i     = '0;

  // Predictor state, updated at accepted handshakes
  logic [NodeW-1:0]     node_mem [STORE_DEPTH];
  logic [RecW-1:0]      model_term = TerminalReset;
  logic                 model_mode = 1'b0;
  lookup_res_t          expected_res_q [$];

  // Generator view: which nodes are safe to point at, and the offset it plans for
  trie_item_t           pending_items_q [$];
  bit                   gen_written [STORE_DEPTH];
  int unsigned          written_list [$];
  logic [RecW-1:0]      gen_term = TerminalReset;
  logic [IdxW-1:0]      path_nodes [MAX_DEPTH];
  bit                   path_bits [MAX_DEPTH];
  int unsigned          path_depth = 1;

  // Driver and monitor bookkeeping
  trie_item_t           drv_item;
  logic                 item_taken = 1'b0;
  int unsigned          idle_left  = 0;
  int unsigned          gap_max    = 5;
  int unsigned          cycle_cnt  = 0;
  int unsigned          err_cnt    = 0;
  int unsigned          n_lookups  = 0;
  int unsigned          n_writes   = 0;
  int unsigned          n_cfg      = 0;
  int unsigned          n_settings = 0;
  int unsigned          status_tally [4] = '{0, 0, 0, 0};
  lookup_res_t          mon_exp;

  ipv4_geo_trie_lookup u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .node_index_i    (node_index_i),
    .left_record_i   (left_record_i),
    .right_record_i  (right_record_i),
    .address_i       (address_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .country_o       (country_o),
    .record_offset_o (record_offset_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    err_cnt++;
  endtask

  // Walk the trie from node 0, top address bit first
  function automatic lookup_res_t predict_lookup(input logic [AddrW-1:0] addr);
    lookup_res_t      res;
    logic [RecW-1:0]  rec;
    logic [RecW-1:0]  diff;
    logic [NodeW-1:0] node;
    logic             ended;
    logic             beyond;
    res.status  = STATUS_NODATA;
    res.country = '0;
    res.offset  = '0;
    rec    = '0;
    ended  = 1'b0;
    beyond = 1'b0;
    for (int lvl = int'(TopBit); lvl >= 0; lvl--) begin
      if (!ended && !beyond) begin
        if (rec >= STORE_DEPTH) begin
          beyond = 1'b1;
        end else begin
          node  = node_mem[rec[IdxW-1:0]];
          rec   = addr[lvl] ? node[NodeW-1:RecW] : node[RecW-1:0];
          ended = (rec >= model_term);
        end
      end
    end
    // out of bits or exact terminal both stay at no data
    if (beyond) begin
      res.status = STATUS_BEYOND;
    end else if (ended && rec != model_term) begin
      if (model_mode) begin
        res.status = STATUS_FOUND;
        res.offset = OffsetW'(rec + 5 * model_term);
      end else begin
        diff = rec - model_term;
        if (diff > LAST_CTRY) begin
          res.status = STATUS_RANGE;
        end else begin
          res.status  = STATUS_FOUND;
          res.country = diff[CountryW-1:0];
        end
      end
    end
    return res;
  endfunction

  // Record value that never leads a walk into an unwritten node
  function automatic logic [RecW-1:0] pick_record(input bit allow_ptr);
    int unsigned t;
    int unsigned v;
    t = 32'(gen_term);
    case ($urandom_range(0, allow_ptr ? 9 : 7))
      0, 1, 2: v = t + $urandom_range(1, LAST_CTRY);
      3:       v = t;
      4:       v = $urandom_range(t, 24'hFFFFFF);
      5:       v = 24'hFFFFFF;
      6, 7:    v = (t > STORE_DEPTH) ? $urandom_range(STORE_DEPTH, t - 1) : t;
      default: v = (written_list.size() > 0) ?
                   written_list[$urandom_range(0, written_list.size() - 1)] : t;
    endcase
    if (v > 24'hFFFFFF) v = t;
    return v[RecW-1:0];
  endfunction

  task automatic push_write(input logic [IdxW-1:0] idx, input logic [RecW-1:0] left,
                            input logic [RecW-1:0] right);
    trie_item_t it;
    it.kind  = KIND_WRITE;
    it.idx   = idx;
    it.left  = left;
    it.right = right;
    it.addr  = AddrW'($urandom);
    pending_items_q.push_back(it);
    if (!gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      written_list.push_back(32'(idx));
    end
  endtask

  task automatic push_lookup(input logic [AddrW-1:0] addr);
    trie_item_t it;
    it.kind  = KIND_LOOKUP;
    it.idx   = IdxW'($urandom);
    it.left  = RecW'($urandom);
    it.right = RecW'($urandom);
    it.addr  = addr;
    pending_items_q.push_back(it);
  endtask

  // Chain of nodes from the root, written deepest first so every pointer is safe
  task automatic build_trie();
    logic [RecW-1:0] on_rec;
    logic [RecW-1:0] off_rec;
    path_depth = ($urandom_range(0, 4) == 0) ? $urandom_range(13, MAX_DEPTH)
                                             : $urandom_range(1, 12);
    path_nodes[0] = '0;
    for (int k = 1; k < path_depth; k++) path_nodes[k] = IdxW'($urandom);
    for (int k = 0; k < path_depth; k++) path_bits[k] = 1'($urandom_range(0, 1));
    for (int k = path_depth - 1; k >= 0; k--) begin
      on_rec  = (k == path_depth - 1) ? pick_record(1'b1) : RecW'(path_nodes[k + 1]);
      off_rec = pick_record(1'b1);
      if (path_bits[k]) push_write(path_nodes[k], off_rec, on_rec);
      else push_write(path_nodes[k], on_rec, off_rec);
    end
  endtask

  // Address that follows the current chain for some or all of its length
  function automatic logic [AddrW-1:0] path_address();
    logic [AddrW-1:0] addr;
    int unsigned      plen;
    addr = AddrW'($urandom);
    plen = (path_depth > 32) ? 32 : path_depth;
    if ($urandom_range(0, 3) == 0) plen = $urandom_range(0, plen);
    for (int k = 0; k < plen; k++) addr[31 - k] = path_bits[k];
    return addr;
  endfunction

  // Block idle: nothing queued, nothing in flight, no result owed
  task automatic wait_drained();
    while (pending_items_q.size() != 0 || start || busy || expected_res_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RecW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CFG_TERMINAL_OFFSET) gen_term = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [RecW-1:0] term, input logic mode,
                           input int unsigned gapmax);
    wait_drained();
    write_reg(CFG_TERMINAL_OFFSET, term);
    write_reg(CFG_RECORD_MODE, (RecW'($urandom) & ~RecW'(1)) | RecW'(mode));
    write_reg(CfgIdxW'($urandom_range(int'(CFG_RECORD_MODE) + 1, (1 << CfgIdxW) - 1)),
              RecW'($urandom));
    // nodes written under an older offset may now point into unwritten nodes
    foreach (gen_written[i]) gen_written[i] = 1'b0;
    written_list.delete();
    gap_max = gapmax;
    n_settings++;
    repeat (3) begin
      build_trie();
      repeat (50) begin
        if ($urandom_range(0, 9) == 0)
          push_write(IdxW'($urandom), pick_record(1'b1), pick_record(1'b1));
        else
          push_lookup(path_address());
      end
    end
  endtask

  // Driver: next item goes out at the falling edge once the last one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start || item_taken)) begin
      if (idle_left > 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (pending_items_q.size() > 0) begin
        drv_item = pending_items_q.pop_front();
        kind_i         <= drv_item.kind;
        node_index_i   <= drv_item.idx;
        left_record_i  <= drv_item.left;
        right_record_i <= drv_item.right;
        address_i      <= drv_item.addr;
        start          <= 1'b1;
        idle_left = $urandom_range(0, gap_max);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: register writes, accepted items and result checks
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;

      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        if (cfg_index_i == CFG_TERMINAL_OFFSET) model_term = cfg_data_i;
        else if (cfg_index_i == CFG_RECORD_MODE) model_mode = cfg_data_i[0];
      end

      // results come strictly in lookup order
      if (done_o) begin
        if (expected_res_q.size() == 0) begin
          report_mismatch($sformatf("result with no lookup pending, status %0d", status_o));
        end else begin
          mon_exp = expected_res_q.pop_front();
          status_tally[mon_exp.status]++;
          if (status_o !== mon_exp.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, mon_exp.status));
          if (country_o !== mon_exp.country)
            report_mismatch($sformatf("country got %0d want %0d",
                                      country_o, mon_exp.country));
          if (record_offset_o !== mon_exp.offset)
            report_mismatch($sformatf("record_offset got %0h want %0h",
                                      record_offset_o, mon_exp.offset));
        end
      end

      if (start && !busy) begin
        if (kind_i == KIND_WRITE) begin
          node_mem[node_index_i] = {right_record_i, left_record_i};
          n_writes++;
        end else begin
          expected_res_q.push_back(predict_lookup(address_i));
          n_lookups++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: hand-built trie at reset settings
    gap_max = 0;
    push_write(16'd5, TerminalReset + 24'd1, TerminalReset + RecW'(LAST_CTRY));
    push_write(16'd6, TerminalReset, TerminalReset + RecW'(LAST_CTRY + 1));
    push_write(16'd7, 24'hFFFFFF, RecW'(STORE_DEPTH));
    push_write(16'd1, 24'd5, 24'd6);
    push_write(16'd2, 24'd7, 24'd2);
    push_write(16'd0, 24'd1, 24'd2);
    push_write(16'hFFFF, 24'hFFFFFF, 24'd0);
    push_lookup(32'h0000_0000);  // country 1
    push_lookup(32'h2000_0000);  // last country
    push_lookup(32'h4000_0000);  // exact terminal
    push_lookup(32'h6000_0000);  // one past last country
    push_lookup(32'h8000_0000);  // all-ones record, out of range
    push_lookup(32'hA000_0000);  // pointer past the store
    push_lookup(32'hC000_0000);
    push_lookup(32'hFFFF_FFFF);  // self loop, bits run out
    wait_drained();
    write_reg(CFG_RECORD_MODE, RecW'(1));
    gap_max = 5;
    push_lookup(32'h0000_0000);
    push_lookup(32'h2000_0000);
    push_lookup(32'h8000_0000);
    push_lookup(32'hA000_0000);
    push_lookup(32'hFFFF_FFFF);

    // Random phases over a spread of settings, extremes included
    run_phase(TerminalReset, 1'b0, 5);
    run_phase(TerminalReset, 1'b1, 0);
    run_phase(24'hFFFFFF, 1'b0, 5);
    run_phase(24'h000000, 1'b1, 5);
    run_phase(24'h000000, 1'b0, 0);
    run_phase(24'h001234, 1'b0, 5);
    run_phase(RecW'(STORE_DEPTH), 1'b1, 5);
    run_phase(RecW'($urandom_range(STORE_DEPTH, 24'hFFFFFF)), 1'($urandom), 3);
    wait_drained();

    $display("Ran %0d lookups, %0d node writes and %0d register writes over %0d settings",
             n_lookups, n_writes, n_cfg, n_settings);
    $display("Outcomes: %0d found, %0d no data, %0d out of range, %0d beyond store",
             status_tally[STATUS_FOUND], status_tally[STATUS_NODATA],
             status_tally[STATUS_RANGE], status_tally[STATUS_BEYOND]);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
